[hw/rtl/xtnc_pkg.sv]
`default_nettype none

package xtnc_pkg;

   // expected name storage: four 64-bit registers of eight bytes each
   localparam int NAME_REG_COUNT     = 4;
   localparam int NAME_REG_BYTES     = 8;
   localparam int NAME_STORE_BYTES   = NAME_REG_COUNT * NAME_REG_BYTES;
   localparam int MAX_NAME_BYTES_DEF = 32;

   localparam int LENGTH_WIDTH = 6;
   localparam int POS_WIDTH    = 7;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NAME_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NAME_BYTES_LO = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NAME_BYTES_HI = 3'd4;

   // characters
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // tag class codes
   typedef logic [1:0] tag_class_type;
   localparam tag_class_type CLASS_OPEN   = 2'd0;
   localparam tag_class_type CLASS_CLOSE  = 2'd1;
   localparam tag_class_type CLASS_SELF   = 2'd2;
   localparam tag_class_type CLASS_BROKEN = 2'd3;

   // name comparison verdict codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_COMPARING = 2'd0;
   localparam verdict_type VERDICT_MATCH     = 2'd1;
   localparam verdict_type VERDICT_MISMATCH  = 2'd2;
   localparam verdict_type VERDICT_BROKEN    = 2'd3;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_TAB) || (b == CH_LF) || (b == CH_FF) || (b == CH_CR)
         || (b == CH_SPACE);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/xml_tag_name_checker_core.sv]
`default_nettype none

// channel  direction  ports                                  word
// req      in         req_valid req_ready req_tag_byte        one tag byte
//                     req_last_byte
// rsp      out        rsp_valid rsp_ready rsp_tag_class       one tag verdict
//                     rsp_name_mismatch
// csr      in         csr_valid csr_ready csr_index csr_data  one register write
//
// One byte per cycle unless a last byte waits for rsp: a byte enters the input
// register, then the compare against the held byte and the flag update land in
// the tag state; a last byte loads the tag's verdict into the result register.
// Reset clears the tag state, the name registers and both valid flags.
// A stall on rsp holds only a word carrying a last byte; other bytes drain.
module xml_tag_name_checker_core #(
   parameter int MAX_NAME_BYTES = xtnc_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_tag_byte,
   input  wire logic                                req_last_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output xtnc_pkg::tag_class_type                  rsp_tag_class,
   output logic                                     rsp_name_mismatch,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [xtnc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [xtnc_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import xtnc_pkg::*;

   localparam int LEN_LIMIT = (MAX_NAME_BYTES < NAME_STORE_BYTES) ?
      MAX_NAME_BYTES : NAME_STORE_BYTES;
   localparam logic [LENGTH_WIDTH-1:0] LEN_LIMIT_V = LENGTH_WIDTH'(LEN_LIMIT);
   localparam logic [POS_WIDTH-1:0]    POS_MAX     = {POS_WIDTH{1'b1}};

   // configuration
   logic [LENGTH_WIDTH-1:0]                           name_length_ff;
   logic [NAME_REG_COUNT-1:0][NAME_REG_BYTES-1:0][7:0] name_ff;
   logic [LENGTH_WIDTH-1:0]                           eff_length;
   logic [CSR_IDX_WIDTH-1:0]                          csr_slot;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_fire;

   // tag state
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           held_ff, held_in;
   logic                 bracket_ff, bracket_in;
   logic                 closing_ff, closing_in;
   verdict_type          verdict_ff, verdict_in;

   // compare of the held byte
   logic [POS_WIDTH-1:0] start_pos;
   logic                 held_valid;
   logic [POS_WIDTH-1:0] cmp_idx;
   logic [7:0]           exp_byte;
   verdict_type          verdict_cmp;

   // end of tag
   logic                 slash_end;
   verdict_type          verdict_end;
   logic [POS_WIDTH-1:0] body_len;
   tag_class_type        class_in;
   logic                 mismatch_in;

   // result register
   logic          rsp_valid_ff;
   tag_class_type rsp_class_ff;
   logic          rsp_mismatch_ff;

   assign csr_ready = 1'b1;
   assign csr_slot  = csr_index - CSR_NAME_BYTES_LO;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_length_ff <= '0;
         name_ff        <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_NAME_LENGTH) begin
            name_length_ff <= csr_data[LENGTH_WIDTH-1:0];
         end else if (csr_index >= CSR_NAME_BYTES_LO && csr_index <= CSR_NAME_BYTES_HI) begin
            name_ff[csr_slot[1:0]] <= csr_data;
         end
      end
   end

   assign eff_length = (name_length_ff > LEN_LIMIT_V) ? LEN_LIMIT_V : name_length_ff;

   // a result-bearing word waits for room in the result register
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_byte_ff <= req_tag_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // held byte compare: name byte index counts from after "<" or "</"
   always_comb begin
      start_pos  = closing_ff ? POS_WIDTH'(2) : POS_WIDTH'(1);
      held_valid = pos_ff > start_pos;
      cmp_idx    = pos_ff - POS_WIDTH'(1) - start_pos;
      exp_byte   = 8'h00;
      if (cmp_idx < {1'b0, eff_length}) begin
         exp_byte = name_ff[cmp_idx[4:3]][cmp_idx[2:0]];
      end
      verdict_cmp = verdict_ff;
      if (verdict_ff == VERDICT_COMPARING) begin
         if (held_ff != exp_byte) begin
            verdict_cmp = (exp_byte == 8'h00 && is_space(held_ff)) ?
               VERDICT_MATCH : VERDICT_MISMATCH;
         end else if (held_ff == 8'h00) begin
            verdict_cmp = VERDICT_BROKEN;
         end
      end
   end

   // classify on the last byte
   always_comb begin
      slash_end   = held_valid && (held_ff == CH_SLASH);
      verdict_end = (held_valid && !slash_end) ? verdict_cmp : verdict_ff;
      body_len    = pos_ff - POS_WIDTH'(1);
      mismatch_in = 1'b0;
      if (pos_ff == '0 || !bracket_ff || s1_byte_ff != CH_GT) begin
         class_in = CLASS_BROKEN;
      end else if (closing_ff) begin
         class_in = slash_end ? CLASS_BROKEN : CLASS_CLOSE;
         body_len = pos_ff - POS_WIDTH'(2);
      end else begin
         class_in = slash_end ? CLASS_SELF : CLASS_OPEN;
         if (slash_end) begin
            body_len = pos_ff - POS_WIDTH'(2);
         end
      end
      if (class_in != CLASS_BROKEN) begin
         if (verdict_end == VERDICT_BROKEN) begin
            class_in = CLASS_BROKEN;
         end else if (verdict_end == VERDICT_MISMATCH) begin
            mismatch_in = 1'b1;
         end else if (verdict_end == VERDICT_COMPARING && body_len < {1'b0, eff_length}) begin
            mismatch_in = 1'b1;
         end
      end
      if (class_in == CLASS_BROKEN) begin
         mismatch_in = 1'b0;
      end
   end

   // next tag state
   always_comb begin
      pos_in     = pos_ff;
      held_in    = held_ff;
      bracket_in = bracket_ff;
      closing_in = closing_ff;
      verdict_in = verdict_ff;
      if (s1_last_ff) begin
         pos_in     = '0;
         held_in    = '0;
         bracket_in = 1'b0;
         closing_in = 1'b0;
         verdict_in = VERDICT_COMPARING;
      end else begin
         if (pos_ff == '0) begin
            bracket_in = (s1_byte_ff == CH_LT);
            closing_in = 1'b0;
            verdict_in = VERDICT_COMPARING;
         end else if (pos_ff == POS_WIDTH'(1)) begin
            closing_in = (s1_byte_ff == CH_SLASH);
         end else if (held_valid) begin
            verdict_in = verdict_cmp;
         end
         held_in = s1_byte_ff;
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         held_ff    <= '0;
         bracket_ff <= 1'b0;
         closing_ff <= 1'b0;
         verdict_ff <= VERDICT_COMPARING;
      end else if (s1_fire) begin
         pos_ff     <= pos_in;
         held_ff    <= held_in;
         bracket_ff <= bracket_in;
         closing_ff <= closing_in;
         verdict_ff <= verdict_in;
      end
   end

   // result register: load on a last byte, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_class_ff    <= class_in;
         rsp_mismatch_ff <= mismatch_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tag_class     = rsp_class_ff;
   assign rsp_name_mismatch = rsp_mismatch_ff;

endmodule

`default_nettype wire

[tb/tb_xml_tag_name_checker_core.sv]
`timescale 1ns / 100ps

module tb_xml_tag_name_checker_core;
   import xtnc_pkg::*;

   localparam int NAME_LIMIT     = MAX_NAME_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int STALL_CYCLES   = 400;

   typedef struct packed {
      tag_class_type cls;
      logic          mismatch;
   } tag_verdict_type;

   typedef enum int {
      SETUP_SHORT_AB,
      SETUP_LETTERS,
      SETUP_FULL,
      SETUP_OVERLONG,
      SETUP_EMPTY,
      SETUP_ALL_ONES,
      SETUP_EMBEDDED_ZERO
   } name_setup_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_tag_byte;
   logic                      req_last_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   tag_class_type             rsp_tag_class;
   logic                      rsp_name_mismatch;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   xml_tag_name_checker_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tag_byte      (req_tag_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tag_class     (rsp_tag_class),
      .rsp_name_mismatch (rsp_name_mismatch),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // shadow of the name registers and of the tag state
   logic [LENGTH_WIDTH-1:0] name_len_reg = '0;
   logic [63:0]             name_store [NAME_REG_COUNT];
   logic [POS_WIDTH-1:0]    tag_pos = '0;
   logic [7:0]              held_char = '0;
   logic                    saw_bracket = 1'b0;
   logic                    closing_tag = 1'b0;
   verdict_type             name_verdict = VERDICT_COMPARING;

   tag_verdict_type verdicts_due [$];
   tag_verdict_type want;

   logic [7:0]  blanks [5] = '{CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_cycles_req = 0;
   int unsigned stall_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_name_len();
      int unsigned n;
      n = name_len_reg;
      if (n > NAME_LIMIT) n = NAME_LIMIT;
      if (n > NAME_STORE_BYTES) n = NAME_STORE_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] name_byte_at(input int unsigned i);
      if (i >= eff_name_len()) return 8'h00;
      return name_store[(i / NAME_REG_BYTES) % NAME_REG_COUNT][(i % NAME_REG_BYTES) * 8 +: 8];
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      foreach (blanks[k]) if (b == blanks[k]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void compare_name_char(input logic [7:0] b, input int unsigned i);
      logic [7:0] n;
      if (name_verdict != VERDICT_COMPARING) return;
      n = name_byte_at(i);
      if (b != n) begin
         name_verdict = (n == 8'h00 && is_blank(b)) ? VERDICT_MATCH : VERDICT_MISMATCH;
      end else if (b == 8'h00) begin
         name_verdict = VERDICT_BROKEN;
      end
   endfunction

   // advance the shadow tag state by one accepted byte
   function automatic void absorb_tag_byte(input logic [7:0] c, input logic is_last);
      int unsigned     idx;
      int unsigned     start;
      int unsigned     body;
      logic            held_ok;
      tag_verdict_type v;
      idx = tag_pos;
      start = closing_tag ? 2 : 1;
      held_ok = (idx >= 1) && ((idx - 1) >= start);
      if (!is_last) begin
         if (idx == 0) begin
            saw_bracket = (c == CH_LT);
            closing_tag = 1'b0;
            name_verdict = VERDICT_COMPARING;
         end else if (idx == 1) begin
            closing_tag = (c == CH_SLASH);
         end else if (held_ok) begin
            compare_name_char(held_char, idx - 1 - start);
         end
         held_char = c;
         if (tag_pos < 7'd127) tag_pos = tag_pos + 7'd1;
         return;
      end
      v.mismatch = 1'b0;
      if (idx == 0 || !saw_bracket || c != CH_GT) begin
         v.cls = CLASS_BROKEN;
      end else begin
         if (closing_tag) begin
            v.cls = CLASS_CLOSE;
            body = idx - 2;
            if (held_ok && held_char == CH_SLASH) v.cls = CLASS_BROKEN;
            else if (held_ok) compare_name_char(held_char, idx - 1 - start);
         end else begin
            v.cls = CLASS_OPEN;
            body = idx - 1;
            if (held_ok && held_char == CH_SLASH) begin
               v.cls = CLASS_SELF;
               body = body - 1;
            end else if (held_ok) begin
               compare_name_char(held_char, idx - 1 - start);
            end
         end
         if (v.cls != CLASS_BROKEN) begin
            if (name_verdict == VERDICT_BROKEN) v.cls = CLASS_BROKEN;
            else if (name_verdict == VERDICT_MISMATCH) v.mismatch = 1'b1;
            else if (name_verdict == VERDICT_COMPARING && body < eff_name_len())
               v.mismatch = 1'b1;
         end
      end
      if (v.cls == CLASS_BROKEN) v.mismatch = 1'b0;
      verdicts_due.push_back(v);
      tag_pos = '0;
      held_char = '0;
      saw_bracket = 1'b0;
      closing_tag = 1'b0;
      name_verdict = VERDICT_COMPARING;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, exp_val, $realtime);
      error_count++;
   endtask

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic write_register(input logic [CSR_IDX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_NAME_LENGTH) name_len_reg = data[LENGTH_WIDTH-1:0];
      else if (index >= CSR_NAME_BYTES_LO && index <= CSR_NAME_BYTES_HI)
         name_store[index - CSR_NAME_BYTES_LO] = data;
      @(negedge clock);
   endtask

   task automatic load_setup(input name_setup_type setup);
      logic [NAME_STORE_BYTES*8-1:0] name_img;
      logic [CSR_DATA_WIDTH-1:0]     len_word;
      int unsigned                   len;
      for (int k = 0; k < NAME_STORE_BYTES; k++) name_img[k*8 +: 8] = rand_letter();
      case (setup)
         SETUP_SHORT_AB: begin
            len = 2;
            name_img[15:0] = 16'h6261;
         end
         SETUP_LETTERS:  len = $urandom_range(1, 12);
         SETUP_FULL:     len = NAME_STORE_BYTES;
         SETUP_OVERLONG: len = 63;
         SETUP_EMPTY: begin
            len = 0;
            for (int k = 0; k < NAME_STORE_BYTES / 4; k++) name_img[k*32 +: 32] = $urandom;
         end
         SETUP_ALL_ONES: begin
            len = 20;
            name_img = '1;
         end
         default: begin
            len = 10;
            name_img[$urandom_range(1, 8) * 8 +: 8] = 8'h00;
         end
      endcase
      // junk above the length field must be dropped
      len_word = {$urandom, $urandom};
      len_word[LENGTH_WIDTH-1:0] = len[LENGTH_WIDTH-1:0];
      write_register(CSR_NAME_LENGTH, len_word);
      for (int k = 0; k < NAME_REG_COUNT; k++)
         write_register(CSR_IDX_WIDTH'(CSR_NAME_BYTES_LO + k), name_img[k*64 +: 64]);
      csr_valid <= 1'b0;
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_tag_byte  <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      absorb_tag_byte(b, is_last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_tag_bytes(input logic [7:0] tag_q [$]);
      foreach (tag_q[k]) send_byte(tag_q[k], k == tag_q.size() - 1);
   endtask

   // mostly well-formed tags built around the expected name
   task automatic send_random_tag();
      logic [7:0]  tag_q [$];
      int unsigned form;
      int unsigned n;
      int unsigned cut;
      n = eff_name_len();
      tag_q = {};
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 8)) tag_q.push_back(8'($urandom_range(255)));
      end else begin
         tag_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_LT);
         form = $urandom_range(2);
         if (form == 1) tag_q.push_back(CH_SLASH);
         case ($urandom_range(4))
            0: for (int k = 0; k < n; k++) tag_q.push_back(name_byte_at(k));
            1: begin
               cut = (n == 0) ? 0 : $urandom_range(n - 1);
               for (int k = 0; k < cut; k++) tag_q.push_back(name_byte_at(k));
            end
            2: begin
               for (int k = 0; k < n; k++) tag_q.push_back(name_byte_at(k));
               repeat ($urandom_range(1, 3)) tag_q.push_back(rand_letter());
            end
            3: begin
               for (int k = 0; k < n; k++) tag_q.push_back(name_byte_at(k));
               if (n > 0)
                  tag_q[tag_q.size() - 1 - $urandom_range(n - 1)] = 8'($urandom_range(255));
            end
            default: repeat ($urandom_range(36)) tag_q.push_back(rand_letter());
         endcase
         case ($urandom_range(9))
            0, 1, 2: begin
               tag_q.push_back(blanks[$urandom_range(4)]);
               repeat ($urandom_range(10)) tag_q.push_back(8'($urandom_range(255)));
            end
            3: begin
               tag_q.push_back(8'h00);
               repeat ($urandom_range(2)) tag_q.push_back(rand_letter());
            end
            4: begin
               // long body to saturate the position counter
               if ($urandom_range(9) == 0)
                  repeat ($urandom_range(120, 140)) tag_q.push_back(8'($urandom_range(255)));
            end
            default: ;
         endcase
         if (form == 2 || (form == 1 && $urandom_range(3) == 0)) tag_q.push_back(CH_SLASH);
         tag_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_GT);
      end
      send_tag_bytes(tag_q);
   endtask

   task automatic run_tags(input int unsigned budget);
      int unsigned first;
      first = bytes_sent;
      while (bytes_sent - first < budget) send_random_tag();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_setup(SETUP_SHORT_AB);
      send_tag_bytes('{CH_LT, 8'h61, 8'h62, CH_GT});
      send_tag_bytes('{CH_LT, CH_SLASH, 8'h61, 8'h62, CH_SLASH, CH_GT});
      send_tag_bytes('{CH_LT, 8'h61, 8'h62, 8'h00, CH_GT});
      send_tag_bytes('{CH_LT, 8'h61, 8'h62, CH_SPACE, CH_SLASH, CH_GT});
      send_tag_bytes('{8'hff});
      send_tag_bytes('{CH_LT, 8'h61, CH_GT});
      drain();
   endtask

   task automatic test_name_lengths();
      send_idle_pct = 16;
      recv_idle_pct = 69;
      load_setup(SETUP_LETTERS);
      run_tags(220);
      drain();
      load_setup(SETUP_FULL);
      run_tags(220);
      drain();
      load_setup(SETUP_OVERLONG);
      run_tags(220);
      drain();
   endtask

   task automatic test_name_contents();
      send_idle_pct = 69;
      recv_idle_pct = 16;
      load_setup(SETUP_EMPTY);
      run_tags(220);
      drain();
      load_setup(SETUP_ALL_ONES);
      run_tags(220);
      drain();
      load_setup(SETUP_EMBEDDED_ZERO);
      run_tags(220);
      drain();
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_setup(SETUP_LETTERS);
      run_tags(250);
      drain();
      load_setup(SETUP_EMBEDDED_ZERO);
      run_tags(250);
      drain();
   endtask

   // hold off the result side until the block stalls its input
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_setup(SETUP_LETTERS);
      stall_cycles_req = STALL_CYCLES;
      run_tags(130);
      drain();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles_req != 0) begin
            stall_left = stall_cycles_req;
            stall_cycles_req = 0;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("verdict word with none pending",
                            8'({rsp_tag_class, rsp_name_mismatch}), 8'h00);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tag_class !== want.cls)
               report_mismatch("tag_class", 8'(rsp_tag_class), 8'(want.cls));
            if (rsp_name_mismatch !== want.mismatch)
               report_mismatch("name_mismatch", 8'(rsp_name_mismatch), 8'(want.mismatch));
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_tag_byte  = '0;
      req_last_byte = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      foreach (name_store[k]) name_store[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_name_lengths();
      test_name_contents();
      test_full_rate();
      test_output_stall();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && verdicts_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
